// ===== hw/rtl/brb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring buffer package
// Shared constants, codes and types of the broadcast ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int MAX_READERS_DEF = 8;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int CFG_W    = 4;
  localparam int RID_IN_W = 3;
  localparam int VALUE_W  = 32;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_RECV = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_ID = 2'd3
  } status_e;

  // One operation as it sits in the input register.
  typedef struct packed {
    cmd_e                cmd;
    logic [RID_IN_W-1:0] rid;
  } op_t;

  // Outcome of one operation, handed from the core to the result stage.
  typedef struct packed {
    status_e status;
    logic    hit;
  } res_t;

endpackage

// ===== hw/rtl/brb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/brb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring buffer core
// Pending-reader masks, reader and write pointers, and the decision for the
// operation held in the input register.
// ----------------------------------------------------------------------------
module brb_core #(
  parameter int SLOTS       = 8,
  parameter int MAX_READERS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  brb_pkg::op_t                        op_i,
  input  logic [brb_pkg::CFG_W-1:0]           num_readers_i,
  input  logic [brb_pkg::RID_IN_W-1:0]        next_rid_i,
  output logic                                we_o,
  output logic [$clog2(SLOTS)-1:0]            waddr_o,
  output logic [$clog2(SLOTS)-1:0]            raddr_o,
  output brb_pkg::res_t                       res_o
);
  import brb_pkg::*;

  localparam int SlotW = $clog2(SLOTS);
  localparam int RidW  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CntW  = $clog2(MAX_READERS + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  logic [MAX_READERS-1:0] pend_q [SLOTS];
  logic [SlotW-1:0]       rptr_q [MAX_READERS];
  logic [SlotW-1:0]       wptr_q;

  logic [CntW-1:0]        n_eff;
  logic [MAX_READERS-1:0] act_mask;
  logic                   full;
  logic                   rid_ok;
  logic [RidW-1:0]        rsel;
  logic [SlotW-1:0]       rp;
  logic                   hit;
  logic [RidW-1:0]        nsel;
  logic [SlotW-1:0]       wptr_nxt;
  logic [SlotW-1:0]       rp_nxt;

  always_comb begin
    if (num_readers_i == '0) begin
      n_eff = CntW'(1);
    end else if (32'(num_readers_i) > MAX_READERS) begin
      n_eff = CntW'(MAX_READERS);
    end else begin
      n_eff = CntW'(num_readers_i);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_READERS; i++) begin
      act_mask[i] = (CntW'(i) < n_eff);
    end
  end

  assign full     = |(pend_q[wptr_q] & act_mask);
  assign rid_ok   = {{CntW{1'b0}}, op_i.rid} < {{RID_IN_W{1'b0}}, n_eff};
  assign rsel     = RidW'(op_i.rid);
  assign rp       = rptr_q[rsel];
  assign wptr_nxt = (wptr_q == LastSlot) ? '0 : wptr_q + SlotW'(1);
  assign rp_nxt   = (rp == LastSlot) ? '0 : rp + SlotW'(1);

  assign we_o    = vld_i && (op_i.cmd == CMD_SEND) && !full;
  assign hit     = vld_i && (op_i.cmd == CMD_RECV) && rid_ok && pend_q[rp][rsel];
  assign waddr_o = wptr_q;

  always_comb begin
    res_o.hit = hit;
    if (op_i.cmd == CMD_SEND) begin
      res_o.status = full ? ST_FULL : ST_OK;
    end else if (!rid_ok) begin
      res_o.status = ST_BAD_ID;
    end else begin
      res_o.status = pend_q[rp][rsel] ? ST_OK : ST_EMPTY;
    end
  end

  // Read address for the item now being accepted. A receive in this cycle by
  // the same reader moves its pointer, so the new pointer is forwarded.
  assign nsel    = RidW'(next_rid_i);
  assign raddr_o = (hit && (nsel == rsel)) ? rp_nxt : rptr_q[nsel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        pend_q[s] <= '0;
      end
      for (int r = 0; r < MAX_READERS; r++) begin
        rptr_q[r] <= '0;
      end
    end else begin
      if (we_o) begin
        pend_q[wptr_q] <= act_mask;
        wptr_q         <= wptr_nxt;
      end
      if (hit) begin
        pend_q[rp][rsel] <= 1'b0;
        rptr_q[rsel]     <= rp_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_wptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !we_o |=> $stable(wptr_q))
    else $error("write pointer moved without a send");

  a_send_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |=> (pend_q[$past(wptr_q)] == $past(act_mask)))
    else $error("sent slot not marked pending for all active readers");

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (res_o.status == ST_OK))
    else $error("successful receive reported a refusal");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_o && hit))
    else $error("send and receive in the same cycle");
`endif

endmodule

// ===== hw/rtl/broadcast_ring_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring buffer
// One writer and several readers share a ring of slots; every active reader
// must read a slot before the writer may overwrite it.
//
//   Channel   Signals                                   Direction
//   command   start, busy, cmd_i, value_i, reader_id_i  in (busy out)
//   result    done_o, status_o, item_o                  out
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i      in (ready out)
//
// An item is taken at every clock edge with start high; busy stays low.
// Its result passes the input register (slot RAM read) and the result register,
// and is shown one cycle long on done_o.
// Reset clears the pending masks, all pointers and sets the reader count to 1.
// The receiver cannot stall the block.
// ----------------------------------------------------------------------------
module broadcast_ring_buffer_top #(
  parameter int SLOTS       = brb_pkg::SLOTS_DEF,
  parameter int MAX_READERS = brb_pkg::MAX_READERS_DEF,
  parameter int DATA_WIDTH  = brb_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd_i,
  input  logic signed [brb_pkg::VALUE_W-1:0]  value_i,
  input  logic [brb_pkg::RID_IN_W-1:0]        reader_id_i,
  output logic                                done_o,
  output logic [brb_pkg::STATUS_W-1:0]        status_o,
  output logic signed [brb_pkg::ITEM_W-1:0]   item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [brb_pkg::CFG_W-1:0]           cfg_data_i
);
  import brb_pkg::*;

  localparam int SlotW = $clog2(SLOTS);

  logic                  accept;
  logic [CFG_W-1:0]      num_readers_q;
  logic                  vld_q;
  op_t                   op_q;
  logic [VALUE_W-1:0]    value_q;
  logic                  fwd_q;
  logic [DATA_WIDTH-1:0] fwd_data_q;

  logic                  we;
  logic [SlotW-1:0]      waddr;
  logic [SlotW-1:0]      raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] rdata_eff;
  res_t                  res;

  logic                  done_q;
  status_e               status_q;
  logic [ITEM_W-1:0]     item_q;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_readers_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_readers_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= accept;
      done_q <= vld_q;
    end
  end

  // A send in the core stage may write the very slot the new item reads.
  always_ff @(posedge clk_i) begin
    op_q.cmd   <= cmd_e'(cmd_i);
    op_q.rid   <= reader_id_i;
    value_q    <= value_i;
    fwd_q      <= we && (waddr == raddr);
    fwd_data_q <= wdata;
  end

  brb_core #(
    .SLOTS       (SLOTS),
    .MAX_READERS (MAX_READERS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (vld_q),
    .op_i          (op_q),
    .num_readers_i (num_readers_q),
    .next_rid_i    (reader_id_i),
    .we_o          (we),
    .waddr_o       (waddr),
    .raddr_o       (raddr),
    .res_o         (res)
  );

  assign wdata = DATA_WIDTH'(value_q);

  brb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rdata_eff = fwd_q ? fwd_data_q : rdata;

  always_ff @(posedge clk_i) begin
    status_q <= res.status;
    item_q   <= res.hit ? ITEM_W'(rdata_eff) : '0;
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign item_o   = $signed(item_q);

endmodule
